FILE: hdl/sdn_pkg.sv
// Shared types, constants and register codes for the signed distance/normal block.
`timescale 1ns / 1ps

package sdn_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int Q15_W       = 16;
  localparam int OFFSET_W    = 32;
  localparam int RADIUS_W    = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [Q15_W-1:0]    Q15_ONE             = 16'sd32767;
  localparam logic [OFFSET_W-1:0] LINE_OFFSET_RESET   = 32'd655360;
  localparam logic [RADIUS_W-1:0] CIRCLE_RADIUS_RESET = 31'd87360;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_RADIUS = 2'd2;

  // shape codes
  localparam logic SHAPE_LINE   = 1'b0;
  localparam logic SHAPE_CIRCLE = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } sdn_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] distance;
    logic signed [Q15_W-1:0]       normal_x;
    logic signed [Q15_W-1:0]       normal_y;
    logic signed [Q15_W-1:0]       tangent_x;
    logic signed [Q15_W-1:0]       tangent_y;
    logic                          degenerate;
  } sdn_out_t;

endpackage

FILE: hdl/signed_distance_normal_2d.sv
// Top level: streaming signed distance, unit normal and tangent for a line or circle.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_stall/in_data carries one query point (Q16.16 x, y).
//   A transfer happens at a clock edge with in_valid high and in_stall low.
//   Result channel out_valid/out_stall/out_data carries distance (Q16.16),
//   normal and tangent (Q1.15) and the degenerate flag, one result per point.
//   Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data writes shape_type,
//   line_offset and circle_radius; cfg_ready is always high. Write only while
//   no point is in flight.
// Throughput and pipeline depth
//   One point per cycle while the output is not stalled. The pipeline depth
//   LAT is the longer of the distance path (COORD_WIDTH+4 stages, set by the
//   one-bit-per-stage square root of x^2+y^2) and the normal path
//   (clog2(COORD_WIDTH+31)+52 stages: normalizing shifter, 32-stage square root
//   and 16-stage divider).
// Reset and stall
//   rst_n (synchronous) empties the pipeline and restores the default line
//   y = 10.0 and radius 1.333. While the output holds a result that the
//   receiver stalls, the whole pipeline freezes and in_stall is raised;
//   nothing is dropped or repeated.

module signed_distance_normal_2d import sdn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sdn_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdn_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int H   = (W + 1) / 2;          // low half for split squaring
  localparam int NW  = W + 31;                // normalizer width
  localparam int NS  = $clog2(NW);            // normalizer stages
  localparam int LD  = W + 4;                 // distance path depth
  localparam int LN  = NS + 52;               // normal path depth
  localparam int L   = (LD > LN) ? LD : LN;
  localparam int DW  = ((W > OFFSET_W) ? W : OFFSET_W) + 2;
  localparam int MW  = W + 3;                 // line distance, signs, zero flag
  localparam int QW  = 32;                    // normal path root width
  localparam int NUM_W = 48;                  // divider remainder width
  localparam int AND_D = QW + 2;              // delay of normalized values to divider

  localparam logic signed [DW-1:0] SAT_HI = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

  // ---------------------------------------------------------------- config
  logic                  shape_r;
  logic [OFFSET_W-1:0]   offset_r;
  logic [RADIUS_W-1:0]   radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= SHAPE_LINE;
      offset_r <= LINE_OFFSET_RESET;
      radius_r <= CIRCLE_RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHAPE_TYPE:    shape_r  <= cfg_data[0];
        CFG_LINE_OFFSET:   offset_r <= cfg_data[OFFSET_W-1:0];
        CFG_CIRCLE_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        default: ;  // no register there: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // All stages advance together; freeze when the output holds a stalled result.
  logic        en;
  logic [L:0]  vld_r;
  logic        out_valid_r;
  sdn_out_t    out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[L-1:0], in_valid};
      out_valid_r <= vld_r[L];
    end
  end

  // ---------------------------------------------------------------- stage A
  // Take magnitudes and signs; the line distance is finished here.
  logic [W-1:0]           ax_r, ay_r;
  logic [MW-1:0]          meta_r [L+1];
  logic signed [DW-1:0]   line_diff;
  logic [W-1:0]           line_sat;
  logic [W-1:0]           ax_a, ay_a;

  assign ax_a = in_data.coord_x[W-1] ? W'(-in_data.coord_x) : in_data.coord_x;
  assign ay_a = in_data.coord_y[W-1] ? W'(-in_data.coord_y) : in_data.coord_y;

  assign line_diff = $signed({{(DW-W){in_data.coord_y[W-1]}}, in_data.coord_y})
                   - $signed({{(DW-OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r});

  always_comb begin
    if (line_diff > SAT_HI)      line_sat = SAT_HI[W-1:0];
    else if (line_diff < SAT_LO) line_sat = SAT_LO[W-1:0];
    else                         line_sat = line_diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= ax_a;
      ay_r      <= ay_a;
      meta_r[0] <= {line_sat, in_data.coord_x[W-1], in_data.coord_y[W-1],
                    (ax_a == '0) && (ay_a == '0)};
      for (int i = 1; i <= L; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- distance path
  logic [2*H-1:0]     llx_r, lly_r;
  logic [W-1:0]       lhx_r, lhy_r;
  logic [2*(W-H)-1:0] hhx_r, hhy_r;
  logic [2*W-1:0]     sqx_r, sqy_r, rad_r;
  logic [W-1:0]       root_d;
  logic [W-1:0]       circ_dist_r;
  logic signed [DW-1:0] circ_diff;

  always_ff @(posedge clk) begin
    if (en) begin
      llx_r <= ax_r[H-1:0] * ax_r[H-1:0];
      lly_r <= ay_r[H-1:0] * ay_r[H-1:0];
      lhx_r <= ax_r[H-1:0] * ax_r[W-1:H];
      lhy_r <= ay_r[H-1:0] * ay_r[W-1:H];
      hhx_r <= ax_r[W-1:H] * ax_r[W-1:H];
      hhy_r <= ay_r[W-1:H] * ay_r[W-1:H];
      sqx_r <= {hhx_r, {(2*H){1'b0}}} + ((2*W)'(lhx_r) << (H+1)) + (2*W)'(llx_r);
      sqy_r <= {hhy_r, {(2*H){1'b0}}} + ((2*W)'(lhy_r) << (H+1)) + (2*W)'(lly_r);
      rad_r <= sqx_r + sqy_r;
    end
  end

  sdn_sqrt_pipe #(.ROOT_W(W)) u_sqrt_dist (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root_d)
  );

  assign circ_diff = $signed({{(DW-W){1'b0}}, root_d})
                   - $signed({{(DW-RADIUS_W){1'b0}}, radius_r});

  always_ff @(posedge clk) begin
    if (en) begin
      if (circ_diff > SAT_HI)      circ_dist_r <= SAT_HI[W-1:0];
      else if (circ_diff < SAT_LO) circ_dist_r <= SAT_LO[W-1:0];
      else                         circ_dist_r <= circ_diff[W-1:0];
    end
  end

  // ---------------------------------------------------------------- normal path
  // Normalize so the larger magnitude's top bit sits at NW-1, one shift step a stage.
  logic [NW-1:0] nvx_r [NS];
  logic [NW-1:0] nvy_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - s);
    logic [NW-1:0] vx_in, vy_in, vor;
    if (s == 0) begin : g_first
      assign vx_in = {31'b0, ax_r};
      assign vy_in = {31'b0, ay_r};
    end else begin : g_next
      assign vx_in = nvx_r[s-1];
      assign vy_in = nvy_r[s-1];
    end
    assign vor = vx_in | vy_in;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vor[NW-1 -: SH] == '0) begin
          nvx_r[s] <= vx_in << SH;
          nvy_r[s] <= vy_in << SH;
        end else begin
          nvx_r[s] <= vx_in;
          nvy_r[s] <= vy_in;
        end
      end
    end
  end

  logic [30:0]   anx, any;
  logic [61:0]   psx_r, psy_r;
  logic [2*QW-1:0] radn_r;
  logic [QW-1:0] q_n;
  logic [61:0]   an_r [AND_D];

  // top 31 bits: exact left shift or truncating right shift
  assign anx = nvx_r[NS-1][NW-1 -: 31];
  assign any = nvy_r[NS-1][NW-1 -: 31];

  always_ff @(posedge clk) begin
    if (en) begin
      psx_r    <= anx * anx;
      psy_r    <= any * any;
      radn_r   <= (2*QW)'(psx_r) + (2*QW)'(psy_r);
      an_r[0]  <= {anx, any};
      for (int i = 1; i < AND_D; i++) begin
        an_r[i] <= an_r[i-1];
      end
    end
  end

  sdn_sqrt_pipe #(.ROOT_W(QW)) u_sqrt_norm (
    .clk  (clk),
    .en   (en),
    .rad  (radn_r),
    .root (q_n)
  );

  // Rounded quotient a*2^15/q, one quotient bit per stage, both components.
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [QW-1:0]    qp_r;
  logic [NUM_W-1:0] remx_r [Q15_W];
  logic [NUM_W-1:0] remy_r [Q15_W];
  logic [Q15_W-1:0] quox_r [Q15_W];
  logic [Q15_W-1:0] quoy_r [Q15_W];
  logic [QW-1:0]    qd_r   [Q15_W];

  always_ff @(posedge clk) begin
    if (en) begin
      numx_r <= {2'b0, an_r[AND_D-1][61:31], 15'b0} + NUM_W'(q_n >> 1);
      numy_r <= {2'b0, an_r[AND_D-1][30:0], 15'b0} + NUM_W'(q_n >> 1);
      qp_r   <= q_n;
    end
  end

  for (genvar i = 0; i < Q15_W; i++) begin : g_div
    logic [NUM_W-1:0] rx_in, ry_in, dsh;
    logic [Q15_W-1:0] qx_in, qy_in;
    logic [QW-1:0]    q_in;
    if (i == 0) begin : g_first
      assign rx_in = numx_r;
      assign ry_in = numy_r;
      assign qx_in = '0;
      assign qy_in = '0;
      assign q_in  = qp_r;
    end else begin : g_next
      assign rx_in = remx_r[i-1];
      assign ry_in = remy_r[i-1];
      assign qx_in = quox_r[i-1];
      assign qy_in = quoy_r[i-1];
      assign q_in  = qd_r[i-1];
    end
    assign dsh = NUM_W'(q_in) << (Q15_W - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        qd_r[i] <= q_in;
        if (rx_in >= dsh) begin
          remx_r[i] <= rx_in - dsh;
          quox_r[i] <= {qx_in[Q15_W-2:0], 1'b1};
        end else begin
          remx_r[i] <= rx_in;
          quox_r[i] <= {qx_in[Q15_W-2:0], 1'b0};
        end
        if (ry_in >= dsh) begin
          remy_r[i] <= ry_in - dsh;
          quoy_r[i] <= {qy_in[Q15_W-2:0], 1'b1};
        end else begin
          remy_r[i] <= ry_in;
          quoy_r[i] <= {qy_in[Q15_W-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp magnitudes to 32767; signs are applied at the output.
  logic [Q15_W-2:0] magx_r, magy_r;
  logic [Q15_W-1:0] qfx, qfy;

  assign qfx = quox_r[Q15_W-1];
  assign qfy = quoy_r[Q15_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      magx_r <= qfx[Q15_W-1] ? Q15_ONE[Q15_W-2:0] : qfx[Q15_W-2:0];
      magy_r <= qfy[Q15_W-1] ? Q15_ONE[Q15_W-2:0] : qfy[Q15_W-2:0];
    end
  end

  // ---------------------------------------------------------------- align paths
  logic [W-1:0]         dist_end;
  logic [2*Q15_W-3:0]   mag_end;

  if (L > LD) begin : g_dpad
    logic [W-1:0] pad_r [L-LD];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= circ_dist_r;
        for (int i = 1; i < L-LD; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end
    assign dist_end = pad_r[L-LD-1];
  end else begin : g_dnopad
    assign dist_end = circ_dist_r;
  end

  if (L > LN) begin : g_npad
    logic [2*Q15_W-3:0] pad_r [L-LN];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= {magx_r, magy_r};
        for (int i = 1; i < L-LN; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end
    assign mag_end = pad_r[L-LN-1];
  end else begin : g_nnopad
    assign mag_end = {magx_r, magy_r};
  end

  // ---------------------------------------------------------------- output register
  logic [W-1:0]     m_line;
  logic             m_sx, m_sy, m_zero;
  logic [Q15_W-1:0] ux, uy, nx_o, ny_o;
  sdn_out_t         res;

  assign {m_line, m_sx, m_sy, m_zero} = meta_r[L];
  assign ux = {1'b0, mag_end[2*Q15_W-3 -: Q15_W-1]};
  assign uy = {1'b0, mag_end[Q15_W-2:0]};

  always_comb begin
    if (shape_r == SHAPE_LINE) begin
      res.distance   = m_line;
      nx_o           = '0;
      ny_o           = Q15_ONE;
      res.degenerate = 1'b0;
    end else begin
      res.distance   = dist_end;
      res.degenerate = m_zero;
      if (m_zero) begin
        nx_o = '0;
        ny_o = '0;
      end else begin
        nx_o = m_sx ? -ux : ux;
        ny_o = m_sy ? -uy : uy;
      end
    end
    res.normal_x  = nx_o;
    res.normal_y  = ny_o;
    res.tangent_x = -ny_o;
    res.tangent_y = nx_o;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_freeze_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved while frozen");

  a_last_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[L] && en |=> out_valid)
    else $error("item at last stage did not reach the output");

  a_degenerate_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.distance <= 0)
    else $error("degenerate result with nonzero normal or positive distance");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x != 16'sh8000 && out_data.normal_y != 16'sh8000)
    else $error("normal component out of Q1.15 unit range");

endmodule

FILE: hdl/sdn_sqrt_pipe.sv
// Pipelined integer square root, one root bit resolved per register stage.
`timescale 1ns / 1ps

module sdn_sqrt_pipe import sdn_pkg::*; #(
  parameter int ROOT_W = COORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [REM_W-1:0]    rem4;
    logic [REM_W-1:0]    trial;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem4  = {rem_in[ROOT_W:0], rad_in[2*ROOT_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g] <= rad_in << 2;
        if (rem4 >= trial) begin
          rem_r[g]  <= rem4 - trial;
          root_r[g] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[g]  <= rem4;
          root_r[g] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

FILE: tb/sv/signed_distance_normal_2d_tb.sv
// Self-checking testbench for the streaming signed distance / normal block.
`timescale 1ns / 1ps

module signed_distance_normal_2d_tb;
  import sdn_pkg::*;

  // Expected results for points in flight, plus the shape registers the
  // block is currently running with.
  class sdn_scoreboard;
    sdn_out_t pending[$];
    logic shape;
    logic [OFFSET_W-1:0] offset;
    logic [RADIUS_W-1:0] radius;
    int errors;

    function new();
      shape = SHAPE_LINE;
      offset = LINE_OFFSET_RESET;
      radius = CIRCLE_RADIUS_RESET;
      errors = 0;
    endfunction

    // Return floor(sqrt(s)) for a 64-bit s, one result bit at a time.
    function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] c;
      logic [127:0] sq;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
        c = res | (64'd1 << b);
        sq = c * c;
        if (sq <= {64'd0, s}) res = c;
      end
      return res;
    endfunction

    // Return floor(sqrt(s)) for a 65-bit sum of squares.
    function automatic logic [63:0] root_floor_wide(logic [64:0] s);
      logic [63:0] res;
      logic [63:0] c;
      logic [127:0] sq;
      res = '0;
      for (int b = 32; b >= 0; b--) begin
        c = res | (64'd1 << b);
        sq = c * c;
        if (sq <= {63'd0, s}) res = c;
      end
      return res;
    endfunction

    function automatic logic signed [Q15_W-1:0] unit_part(logic [63:0] a, logic [63:0] q,
                                                           logic neg);
      logic [63:0] n;
      n = (a * 64'd32768 + q / 2) / q;
      if (n > 64'd32767) n = 64'd32767;
      return neg ? -$signed(n[15:0]) : $signed(n[15:0]);
    endfunction

    // Note one accepted point: compute and queue its result.
    function void note_point(sdn_in_t p);
      sdn_out_t r;
      logic signed [65:0] d;
      logic [63:0] ax, ay, m, mag, q;
      logic [64:0] s2;
      r = '0;
      if (shape == SHAPE_LINE) begin
        d = 66'(p.coord_y) - 66'($signed(offset));
        r.normal_y = Q15_ONE;
      end else begin
        ax = p.coord_x < 0 ? 64'(-65'(p.coord_x)) : 64'(p.coord_x);
        ay = p.coord_y < 0 ? 64'(-65'(p.coord_y)) : 64'(p.coord_y);
        s2 = 65'(ax * ax) + 65'(ay * ay);
        mag = root_floor_wide(s2);
        d = $signed({2'b00, mag}) - $signed({35'd0, radius});
        if (ax == 0 && ay == 0) begin
          r.degenerate = 1'b1;
        end else begin
          m = ax > ay ? ax : ay;
          while (m < (64'd1 << 30)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
          end
          while (m >= (64'd1 << 31)) begin
            ax >>= 1; ay >>= 1; m >>= 1;
          end
          q = root_floor(ax * ax + ay * ay);
          r.normal_x = unit_part(ax, q, p.coord_x < 0);
          r.normal_y = unit_part(ay, q, p.coord_y < 0);
        end
      end
      if (d > 66'sd2147483647) d = 66'sd2147483647;
      if (d < -66'sd2147483648) d = -66'sd2147483648;
      r.distance = d[31:0];
      r.tangent_x = -r.normal_y;
      r.tangent_y = r.normal_x;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    // Compare one accepted result against the oldest expectation.
    task check_result(sdn_out_t got);
      sdn_out_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.distance), 0);
        return;
      end
      w = pending.pop_front();
      if (got.distance !== w.distance) report("distance", 64'(got.distance), 64'(w.distance));
      if (got.normal_x !== w.normal_x) report("normal_x", 64'(got.normal_x), 64'(w.normal_x));
      if (got.normal_y !== w.normal_y) report("normal_y", 64'(got.normal_y), 64'(w.normal_y));
      if (got.tangent_x !== w.tangent_x)
        report("tangent_x", 64'(got.tangent_x), 64'(w.tangent_x));
      if (got.tangent_y !== w.tangent_y)
        report("tangent_y", 64'(got.tangent_y), 64'(w.tangent_y));
      if (got.degenerate !== w.degenerate)
        report("degenerate", 64'(got.degenerate), 64'(w.degenerate));
    endtask
  endclass

  localparam int LATENCY = 70;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sdn_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sdn_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SHAPE_TYPE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sdn_scoreboard sb = new();
  int send_idle_pct = 0;   // chance of an idle cycle between transfers
  int stall_pct = 0;       // chance the receiver stalls a cycle
  int hold_off = 0;        // cycles of forced receiver stall still to go
  longint cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  signed_distance_normal_2d dut (.*);

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: check each result transfer, then decide the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one point; hold it until the transfer, note it then.
  // Valid stays high after the transfer; idle cycles and drain() drop it.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{coord_x: x, coord_y: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(in_data);
  endtask

  // Wait until every queued result has come, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SHAPE_TYPE) sb.shape = val[0];
    else if (idx == CFG_LINE_OFFSET) sb.offset = val;
    else if (idx == CFG_CIRCLE_RADIUS) sb.radius = val[RADIUS_W-1:0];
    @(posedge clk);
  endtask

  // Random coordinate: mix of extremes, small values and full range.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $signed($urandom_range(3)) - 2;
      1: return $signed($urandom_range(2000000)) - 1000000;
      2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                  : 32'sh80000000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_points();
    send_point(0, 0);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh80000000, 0);
    send_point(0, 32'sh7fffffff);
    send_point(1, 0);
    send_point(0, -1);
    send_point(-65536, 65536);
    send_point(32'sh00018000, -32'sh00020000);
    send_point(32'sh0aaaaaaa, 32'sh55555555);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_point(rand_coord(), rand_coord());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: line y = 10.0.
    directed_points();
    drain();
    write_reg(CFG_SHAPE_TYPE, 32'(SHAPE_CIRCLE));
    directed_points();
    drain();
    write_reg(CFG_CIRCLE_RADIUS, 32'h7fffffff);
    write_reg(CFG_LINE_OFFSET, 32'h80000000);
    directed_points();
    drain();
    write_reg(CFG_SHAPE_TYPE, 32'(SHAPE_LINE));
    directed_points();
    drain();

    // Receiver holds off while the sender keeps offering: pipe fills up.
    hold_off = 200;
    random_phase(150, 0, 0);
    drain();

    write_reg(CFG_LINE_OFFSET, 32'h7fffffff);
    random_phase(150, 84, 0);
    drain();
    write_reg(CFG_SHAPE_TYPE, 32'(SHAPE_CIRCLE));
    write_reg(CFG_CIRCLE_RADIUS, 32'h0);
    random_phase(250, 0, 84);
    drain();
    write_reg(CFG_CIRCLE_RADIUS, $urandom);
    random_phase(250, 12, 12);
    drain();
    write_reg(CFG_CIRCLE_RADIUS, 32'(CIRCLE_RADIUS_RESET));
    random_phase(250, 0, 0);
    drain();
    write_reg(CFG_SHAPE_TYPE, 32'(SHAPE_LINE));
    write_reg(CFG_LINE_OFFSET, $urandom);
    random_phase(200, 12, 84);
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
